// File: rtl/free_block_bitmap_allocator_unit_macros.svh
// Assertion macros for the free-block bitmap allocator checker.
// Depends on nothing; included by the checker file only.
`ifndef FREE_BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FBBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/fbba_pkg.sv
// Shared types and constants of the free-block bitmap allocator.
// No dependencies; used by the interfaces, the divider, the top level and the checker.
package fbba_pkg;

	localparam int BLK_W      = 17;
	localparam int NUM_W      = 16;
	localparam int ACT_W      = 2;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [BLK_W-1:0] USED_MAX = 17'h1FFFF;

	localparam logic [BLK_W-1:0] TOTAL_RST    = 17'd65536;
	localparam logic [NUM_W-1:0] RESERVED_RST = 16'd2;
	localparam logic [NUM_W-1:0] ROOT_RST     = 16'd32768;

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC = 2'd0,
		ACT_MARK  = 2'd1,
		ACT_FREE  = 2'd2
	} action_t;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT     = 2'd2;

endpackage

// File: rtl/fbba_if.sv
// Request and response channel interfaces of the block allocator.
// Depends on fbba_pkg for the field widths.
interface fbba_req_if;
	logic                         valid;
	logic                         ready;
	logic [fbba_pkg::ACT_W-1:0]   action;
	logic [fbba_pkg::NUM_W-1:0]   block_index;

	modport source (output valid, output action, output block_index, input ready);
	modport sink (input valid, input action, input block_index, output ready);
endinterface

interface fbba_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [fbba_pkg::NUM_W-1:0]   block_out;
	logic [fbba_pkg::STAT_W-1:0]  status;
	logic [fbba_pkg::BLK_W-1:0]   used_total;

	modport source (output valid, output block_out, output status, output used_total,
		input ready);
	modport sink (input valid, input block_out, input status, input used_total,
		output ready);
endinterface

// File: rtl/free_block_bitmap_allocator_unit.sv
// Free-block bitmap allocator: free map memory, next-fit hint and used count.
// Depends on fbba_pkg, fbba_if (channel interfaces) and fbba_div.
//
//   channel | direction | handshake      | payload
//   req     | in        | valid / ready  | action, block_index
//   rsp     | out       | valid / ready  | block_out, status, used_total
//   cfg     | in        | cfg_we         | cfg_index, cfg_data
//
// After reset a clearing pass writes every map word free (MAP_WORDS words, 2048 by
// default); req.ready stays low meanwhile, cfg writes are taken.
// Mark and free go through accept, index split with word read, write back and result.
// Allocate goes through accept, segment setup, index split with word read, a scan of
// one map word after another and result; a search that wraps into the lower region
// runs setup and split again. The single-read map port sets the pace of the scan.
// A finished result waits in the output register while rsp.ready is low.
module free_block_bitmap_allocator_unit #(
	parameter int MAX_BLOCKS = 65536,
	parameter int WORD_BITS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	fbba_req_if.sink                          req,
	fbba_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [fbba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fbba_pkg::CFG_DATA_W-1:0]   cfg_data
);
	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int IDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int BLK_W     = fbba_pkg::BLK_W;
	localparam int NUM_W     = fbba_pkg::NUM_W;
	localparam int BASE_W    = BLK_W + 1;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_SEG   = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_RMW   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t                     state_q;

	logic [BLK_W-1:0]           total_q;
	logic [NUM_W-1:0]           resv_q;
	logic [NUM_W-1:0]           root_q;
	logic [NUM_W-1:0]           hint_q;
	logic [BLK_W-1:0]           used_q;
	logic [IDX_W-1:0]           clr_q;

	fbba_pkg::action_t          act_q;
	logic [NUM_W-1:0]           blk_q;
	logic [BLK_W-1:0]           lo_q;
	logic [BLK_W-1:0]           hi_q;
	logic [BLK_W-1:0]           lo2_q;
	logic [BLK_W-1:0]           hi2_q;
	logic                       seg2_q;
	logic [BLK_W-1:0]           hi_i_q;
	logic [BASE_W-1:0]          base_q;
	logic [IDX_W-1:0]           word_q;
	logic [BIT_W-1:0]           sbit_q;
	logic                       first_q;
	logic [NUM_W-1:0]           res_blk_q;
	logic [fbba_pkg::STAT_W-1:0] res_st_q;

	logic                       out_vld_q;
	logic [NUM_W-1:0]           out_blk_q;
	logic [fbba_pkg::STAT_W-1:0] out_st_q;
	logic [BLK_W-1:0]           out_used_q;

	logic [WORD_BITS-1:0]       mem [MAP_WORDS];
	logic [WORD_BITS-1:0]       rdata_q;

	logic                       mem_we;
	logic [IDX_W-1:0]           mem_waddr;
	logic [WORD_BITS-1:0]       mem_wdata;
	logic                       mem_re;
	logic [IDX_W-1:0]           mem_raddr;

	logic                       acc;
	logic [BLK_W-1:0]           eff_total;
	logic [BLK_W-1:0]           req_blk;
	logic [BLK_W-1:0]           resv_ext;
	logic [BLK_W-1:0]           root_ext;
	logic                       req_in_map;
	logic [NUM_W-1:0]           start_h;
	logic [BLK_W-1:0]           lower_end;

	logic                       dv_start;
	logic [BLK_W-1:0]           dv_num;
	logic                       dv_done;
	logic [BLK_W-1:0]           dv_quo;
	logic [BLK_W-1:0]           dv_base;
	logic [BIT_W-1:0]           dv_rem;

	logic [BASE_W-1:0]          rem_w;
	logic [WORD_BITS-1:0]       cand;
	logic                       hit;
	logic [BIT_W-1:0]           hit_k;
	logic [BASE_W-1:0]          base_nxt;
	logic                       seg_end;
	logic [BASE_W-1:0]          found;
	logic [WORD_BITS-1:0]       one_w;
	logic                       hint_back;

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	assign eff_total  = (32'(total_q) > 32'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS) : total_q;
	assign req_blk    = BLK_W'(req.block_index);
	assign resv_ext   = BLK_W'(resv_q);
	assign root_ext   = BLK_W'(root_q);
	assign req_in_map = (req_blk >= resv_ext) && (req_blk < eff_total);
	assign start_h    = (hint_q < resv_q) ? resv_q : hint_q;
	assign lower_end  = (root_ext < eff_total) ? root_ext : eff_total;

	// split a block's map index once per segment or per mark/free
	assign dv_start = (state_q == S_SEG) ? (lo_q < hi_q) :
		(acc && (req.action == fbba_pkg::ACT_MARK || req.action == fbba_pkg::ACT_FREE)
			&& req_in_map);
	assign dv_num   = (state_q == S_SEG) ? (lo_q - resv_ext) : (req_blk - resv_ext);

	fbba_div #(
		.WORD_BITS (WORD_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.done   (dv_done),
		.quo    (dv_quo),
		.base   (dv_base),
		.rem    (dv_rem)
	);

	// window the current word to the segment, then pick its lowest free bit
	assign rem_w = BASE_W'(hi_i_q) - base_q;
	assign one_w = WORD_BITS'(1);

	always_comb begin
		for (int k = 0; k < WORD_BITS; k++) begin
			cand[k] = rdata_q[k] && (!first_q || (BIT_W'(k) >= sbit_q))
				&& (BASE_W'(k) < rem_w);
		end
	end

	always_comb begin
		hit_k = '0;
		for (int k = WORD_BITS - 1; k >= 0; k--) begin
			if (cand[k]) hit_k = BIT_W'(k);
		end
	end

	assign hit      = |cand;
	assign base_nxt = base_q + BASE_W'(WORD_BITS);
	assign seg_end  = (base_nxt >= BASE_W'(hi_i_q));
	assign found    = base_q + BASE_W'(hit_k) + BASE_W'(resv_q);

	assign hint_back = ((hint_q < root_q) && (blk_q >= root_q)) ||
		((((hint_q >= root_q) && (blk_q >= root_q)) ||
		((hint_q < root_q) && (blk_q < root_q))) && (blk_q < hint_q));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = word_q;
		mem_wdata = rdata_q;
		mem_re    = 1'b0;
		mem_raddr = word_q;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '1;
			end
			S_DIV: begin
				mem_re    = dv_done;
				mem_raddr = IDX_W'(dv_quo);
			end
			S_SCAN: begin
				if (hit) begin
					mem_we    = 1'b1;
					mem_wdata = rdata_q & ~(one_w << hit_k);
				end else if (!seg_end) begin
					mem_re    = 1'b1;
					mem_raddr = word_q + 1'b1;
				end
			end
			S_RMW: begin
				mem_we = 1'b1;
				if (act_q == fbba_pkg::ACT_FREE) begin
					mem_wdata = rdata_q | (one_w << sbit_q);
				end else begin
					mem_wdata = rdata_q & ~(one_w << sbit_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			total_q    <= fbba_pkg::TOTAL_RST;
			resv_q     <= fbba_pkg::RESERVED_RST;
			root_q     <= fbba_pkg::ROOT_RST;
			hint_q     <= '0;
			used_q     <= '0;
			clr_q      <= '0;
			act_q      <= fbba_pkg::ACT_ALLOC;
			blk_q      <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			lo2_q      <= '0;
			hi2_q      <= '0;
			seg2_q     <= 1'b0;
			hi_i_q     <= '0;
			base_q     <= '0;
			word_q     <= '0;
			sbit_q     <= '0;
			first_q    <= 1'b0;
			res_blk_q  <= '0;
			res_st_q   <= fbba_pkg::ST_OK;
			out_vld_q  <= 1'b0;
			out_blk_q  <= '0;
			out_st_q   <= fbba_pkg::ST_OK;
			out_used_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fbba_pkg::CFG_TOTAL:    total_q <= cfg_data;
					fbba_pkg::CFG_RESERVED: resv_q  <= cfg_data[NUM_W-1:0];
					fbba_pkg::CFG_ROOT:     root_q  <= cfg_data[NUM_W-1:0];
					default: ;
				endcase
			end

			// S_DONE reloads the output register itself
			if (rsp.ready && state_q != S_DONE) out_vld_q <= 1'b0;

			case (state_q)
				S_CLEAR: begin
					if (clr_q == IDX_W'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (acc) begin
						blk_q <= req.block_index;
						case (req.action)
							fbba_pkg::ACT_ALLOC: begin
								act_q <= fbba_pkg::ACT_ALLOC;
								lo_q  <= BLK_W'(start_h);
								lo2_q <= resv_ext;
								hi2_q <= lower_end;
								if (start_h >= root_q) begin
									hi_q   <= eff_total;
									seg2_q <= 1'b1;
								end else begin
									hi_q   <= lower_end;
									seg2_q <= 1'b0;
								end
								state_q <= S_SEG;
							end
							fbba_pkg::ACT_MARK, fbba_pkg::ACT_FREE: begin
								act_q <= fbba_pkg::action_t'(req.action);
								if (req_in_map) begin
									state_q <= S_DIV;
								end else begin
									res_blk_q <= req.block_index;
									res_st_q  <= fbba_pkg::ST_RANGE;
									state_q   <= S_DONE;
								end
							end
							default: begin
								res_blk_q <= req.block_index;
								res_st_q  <= fbba_pkg::ST_RANGE;
								state_q   <= S_DONE;
							end
						endcase
					end
				end
				S_SEG: begin
					if (lo_q < hi_q) begin
						hi_i_q  <= hi_q - resv_ext;
						state_q <= S_DIV;
					end else if (seg2_q) begin
						lo_q   <= lo2_q;
						hi_q   <= hi2_q;
						seg2_q <= 1'b0;
					end else begin
						res_blk_q <= '0;
						res_st_q  <= fbba_pkg::ST_NONE;
						state_q   <= S_DONE;
					end
				end
				S_DIV: begin
					if (dv_done) begin
						word_q  <= IDX_W'(dv_quo);
						base_q  <= BASE_W'(dv_base);
						sbit_q  <= dv_rem;
						first_q <= 1'b1;
						state_q <= (act_q == fbba_pkg::ACT_ALLOC) ? S_SCAN : S_RMW;
					end
				end
				S_SCAN: begin
					if (hit) begin
						if (used_q != fbba_pkg::USED_MAX) used_q <= used_q + 1'b1;
						hint_q    <= found[NUM_W-1:0];
						res_blk_q <= found[NUM_W-1:0];
						res_st_q  <= fbba_pkg::ST_OK;
						state_q   <= S_DONE;
					end else if (seg_end) begin
						// segment exhausted: force it empty and fall back to setup
						lo_q    <= hi_q;
						state_q <= S_SEG;
					end else begin
						word_q  <= word_q + 1'b1;
						base_q  <= base_nxt;
						first_q <= 1'b0;
					end
				end
				S_RMW: begin
					if (act_q == fbba_pkg::ACT_FREE) begin
						if (used_q != '0) used_q <= used_q - 1'b1;
						if (hint_back) hint_q <= blk_q;
					end else begin
						if (used_q != fbba_pkg::USED_MAX) used_q <= used_q + 1'b1;
						hint_q <= blk_q;
					end
					res_blk_q <= blk_q;
					res_st_q  <= fbba_pkg::ST_OK;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_vld_q || rsp.ready) begin
						out_vld_q  <= 1'b1;
						out_blk_q  <= res_blk_q;
						out_st_q   <= res_st_q;
						out_used_q <= used_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.block_out  = out_blk_q;
	assign rsp.status     = out_st_q;
	assign rsp.used_total = out_used_q;

endmodule

// File: rtl/fbba_div.sv
// Two-stage splitter of a map bit index into word, bit and word base.
// Divides by the constant word size with a scaled reciprocal; depends on fbba_pkg.
module fbba_div #(
	parameter int WORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fbba_pkg::BLK_W-1:0]   num,
	output logic                         done,
	output logic [fbba_pkg::BLK_W-1:0]   quo,
	output logic [fbba_pkg::BLK_W-1:0]   base,
	output logic [$clog2(WORD_BITS)-1:0] rem
);
	localparam int BIT_W   = $clog2(WORD_BITS);
	localparam int SHIFT   = 24;
	localparam int PROD_W  = fbba_pkg::BLK_W + SHIFT;
	localparam longint RECIP = ((longint'(1) << SHIFT) + WORD_BITS - 1) / WORD_BITS;

	logic [PROD_W-1:0]            prod;
	logic [fbba_pkg::BLK_W-1:0]   base_c;
	logic [fbba_pkg::BLK_W-1:0]   rem_c;

	logic                         vld_s1;
	logic [fbba_pkg::BLK_W-1:0]   quo_s1;
	logic [fbba_pkg::BLK_W-1:0]   num_s1;
	logic                         vld_s2;
	logic [fbba_pkg::BLK_W-1:0]   quo_s2;
	logic [fbba_pkg::BLK_W-1:0]   base_s2;
	logic [BIT_W-1:0]             rem_s2;

	// reciprocal error stays below one step for every 17-bit index
	assign prod   = PROD_W'(num) * PROD_W'(RECIP);
	assign base_c = fbba_pkg::BLK_W'(32'(quo_s1) * WORD_BITS);
	assign rem_c  = num_s1 - base_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			quo_s1  <= '0;
			num_s1  <= '0;
			quo_s2  <= '0;
			base_s2 <= '0;
			rem_s2  <= '0;
		end else begin
			vld_s1  <= start;
			vld_s2  <= vld_s1;
			quo_s1  <= prod[SHIFT +: fbba_pkg::BLK_W];
			num_s1  <= num;
			quo_s2  <= quo_s1;
			base_s2 <= base_c;
			rem_s2  <= rem_c[BIT_W-1:0];
		end
	end

	assign done = vld_s2;
	assign quo  = quo_s2;
	assign base = base_s2;
	assign rem  = rem_s2;

endmodule

// File: rtl/fbba_chk.sv
// Port-level checker for the block allocator, bound to the top level below.
// Depends on fbba_pkg and the assertion macros header.
`include "free_block_bitmap_allocator_unit_macros.svh"

module fbba_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [fbba_pkg::NUM_W-1:0]    rsp_block_out,
	input logic [fbba_pkg::STAT_W-1:0]   rsp_status
);

	// an accepted item keeps the block busy for at least the next cycle
	`FBBA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready, "block ready right after accepting an item")

	// a failed allocation reports block zero
	`FBBA_ASSERT_NOW(a_none_is_zero, clk, arst_n, rsp_valid && rsp_status == fbba_pkg::ST_NONE, rsp_block_out == '0, "no-free result carries a nonzero block")

	`FBBA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_block_out) && $stable(rsp_status), "stalled result changed")

endmodule

bind free_block_bitmap_allocator_unit fbba_chk u_fbba_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_block_out (rsp.block_out),
	.rsp_status    (rsp.status)
);
